// File: rtl/grr_pkg.sv
// Shared constants and types for the group reverse reorder block.
package grr_pkg;

  localparam int GRR_MAX_GROUP = 16;
  localparam int GRR_DATA_W    = 32;
  localparam int GRR_CFG_W     = 5;

  // Classification of one accepted request, handed from front to back.
  typedef struct packed {
    logic rev;   // group filled: emit reversed
    logic emit;  // this request closes a group or the list
    logic eol;   // end of list
  } grr_flags_t;

  localparam int GRR_FLAGS_W = $bits(grr_flags_t);

endpackage

// File: rtl/grr_queue.sv
// Two-entry queue between the front and back sections.
module grr_queue
  import grr_pkg::*;
#(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= wdata;
    end
  end

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = slot_r[rp_r];

endmodule

// File: rtl/grr_front.sv
// Front section: group size register, request intake and group classification.
module grr_front
  import grr_pkg::*;
#(
  parameter int MAX_GROUP = GRR_MAX_GROUP,
  parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [GRR_CFG_W-1:0]  cfg_wr_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [GRR_DATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [GRR_DATA_W-1:0] q_value,
  output grr_flags_t            q_flags,
  output logic [IDX_W-1:0]      q_idx
);

  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam int KW    = (CNT_W > GRR_CFG_W) ? CNT_W : GRR_CFG_W;

  logic [GRR_CFG_W-1:0] gsize_r;
  logic [IDX_W-1:0]     fill_r;
  logic [IDX_W-1:0]     fill_nxt;
  logic [GRR_CFG_W-1:0] k_eff;
  logic [CNT_W-1:0]     n_cnt;
  logic                 full_grp;

  always_comb begin
    k_eff = (gsize_r == '0) ? GRR_CFG_W'(1) : gsize_r;
    n_cnt = CNT_W'(fill_r) + CNT_W'(1);
    // A size above the store depth saturates, so a full store always closes.
    full_grp = (KW'(n_cnt) >= KW'(k_eff)) || (n_cnt == CNT_W'(MAX_GROUP));
  end

  assign in_tready     = !q_full;
  assign q_push        = in_tvalid && in_tready;
  assign q_value       = in_tdata;
  assign q_idx         = fill_r;
  assign q_flags.rev   = full_grp;
  assign q_flags.emit  = full_grp || in_tlast;
  assign q_flags.eol   = in_tlast;

  always_comb begin
    fill_nxt = fill_r;
    if (q_push) begin
      fill_nxt = q_flags.emit ? '0 : fill_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsize_r <= GRR_CFG_W'(1);
      fill_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        gsize_r <= cfg_wr_data;
      end
      fill_r <= fill_nxt;
    end
  end

endmodule

// File: rtl/grr_back.sv
// Back section: group store and the result sequencer that replays groups.
module grr_back
  import grr_pkg::*;
#(
  parameter int MAX_GROUP = GRR_MAX_GROUP,
  parameter int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  output logic                  q_pop,
  input  logic [GRR_DATA_W-1:0] q_value,
  input  grr_flags_t            q_flags,
  input  logic [IDX_W-1:0]      q_idx,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [GRR_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SHOW = 2'd2;

  logic [GRR_DATA_W-1:0] store_r [MAX_GROUP];
  logic [GRR_DATA_W-1:0] rd_r;
  logic                  last_r;
  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic [IDX_W-1:0]      addr_r;
  logic [IDX_W-1:0]      addr_nxt;
  logic [IDX_W-1:0]      end_r;
  logic                  rev_r;
  logic                  eol_r;

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop && q_flags.emit) begin
          state_nxt = S_READ;
          addr_nxt  = q_flags.rev ? q_idx : '0;
        end
      end
      S_READ: begin
        state_nxt = S_SHOW;
      end
      S_SHOW: begin
        if (out_tready) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_READ;
            addr_nxt  = rev_r ? addr_r - IDX_W'(1) : addr_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (q_pop) begin
      end_r <= q_idx;
      rev_r <= q_flags.rev;
      eol_r <= q_flags.eol;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      store_r[q_idx] <= q_value;
    end
    if (state_r == S_READ) begin
      rd_r   <= store_r[addr_r];
      last_r <= rev_r ? (addr_r == '0) : (addr_r == end_r);
    end
  end

  assign out_tvalid = (state_r == S_SHOW);
  assign out_tdata  = rd_r;
  assign out_tlast  = last_r;
  assign out_tuser  = last_r && eol_r;

endmodule

// File: rtl/group_reverse_reorder.sv
// Top level of the group reverse reorder block.
// Values arrive one request per cycle on the in_ stream (in_tlast ends a list) and are
// buffered in groups of cfg group size (0 acts as 1, values above MAX_GROUP saturate).
// A filled group is replayed in reverse order; a partial group at list end is replayed
// in arrival order. out_tlast marks the last result of a group, out_tuser the last
// result of the list. Intake runs through a two-entry queue, so it accepts one request
// per cycle while that queue has room; the back sequencer writes each popped request into
// the single-port group store, then replays each result as a registered read of the store
// followed by presenting it until out_tready, and pops no new request while a group is
// replayed. No clearing pass is needed after reset.
module group_reverse_reorder
  import grr_pkg::*;
#(
  parameter int MAX_GROUP = GRR_MAX_GROUP
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [GRR_CFG_W-1:0]  cfg_wr_data,   // group_size
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [GRR_DATA_W-1:0] in_tdata,      // [31:0] value
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [GRR_DATA_W-1:0] out_tdata,     // [31:0] out_value
  output logic                  out_tlast,
  output logic                  out_tuser      // [0] list_done
);

  localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int Q_W   = GRR_DATA_W + GRR_FLAGS_W + IDX_W;

  logic                  q_push;
  logic                  q_pop;
  logic                  q_full;
  logic                  q_empty;
  logic [GRR_DATA_W-1:0] f_value;
  grr_flags_t            f_flags;
  logic [IDX_W-1:0]      f_idx;
  logic [GRR_DATA_W-1:0] b_value;
  grr_flags_t            b_flags;
  logic [IDX_W-1:0]      b_idx;
  logic [Q_W-1:0]        q_wdata;
  logic [Q_W-1:0]        q_rdata;

  grr_front #(
    .MAX_GROUP (MAX_GROUP),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_value     (f_value),
    .q_flags     (f_flags),
    .q_idx       (f_idx)
  );

  assign q_wdata = {f_value, f_flags, f_idx};
  assign {b_value, b_flags, b_idx} = q_rdata;

  grr_queue #(
    .W (Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  grr_back #(
    .MAX_GROUP (MAX_GROUP),
    .IDX_W     (IDX_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_value    (b_value),
    .q_flags    (b_flags),
    .q_idx      (b_idx),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/grr_checker.sv
// Port-level checks for the group reverse reorder block, bound to the top level.
module grr_checker
  import grr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [GRR_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("list end without group end");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented right after reset");

  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("intake not ready after reset");

endmodule

bind group_reverse_reorder grr_checker u_grr_checker (.*);
